[hw/rtl/pcl_pkg.sv]
// Shared types and constants for the polygon rectangle clipper.
// No dependencies; used by pcl_div and polygon_rect_clipper.
`default_nettype none
package pcl_pkg;

  localparam int MAX_VERTS = 32;
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;

  // clip sides, in pass order
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_TOP    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_LEFT   = 2'd0;
  localparam logic [1:0] CFG_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_RIGHT  = 2'd2;
  localparam logic [1:0] CFG_TOP    = 2'd3;

  localparam logic signed [COORD_W-1:0] RST_LEFT   = 24'sd25600;
  localparam logic signed [COORD_W-1:0] RST_BOTTOM = 24'sd25600;
  localparam logic signed [COORD_W-1:0] RST_RIGHT  = 24'sd102400;
  localparam logic signed [COORD_W-1:0] RST_TOP    = 24'sd102400;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] num;
    logic signed [DIFF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/pcl_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pcl_pkg.
`default_nettype none
module pcl_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pcl_pkg::div_req_t req,
  output pcl_pkg::div_rsp_t      rsp
);
  localparam int PW = pcl_pkg::PROD_W;
  localparam int DW = pcl_pkg::DIFF_W;

  logic [PW-1:0] quo;
  logic [DW:0]   rem;
  logic [DW-1:0] den_mag;
  logic          neg;
  logic [6:0]    cnt;
  logic          done;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem[DW-1:0], quo[PW-1]};
  assign take  = trial >= {1'b0, den_mag};

  // shift-subtract on magnitudes, sign applied at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo     <= req.num[PW-1] ? PW'(-req.num) : PW'(req.num);
        den_mag <= req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
        neg     <= req.num[PW-1] ^ req.den[DW-1];
        rem     <= '0;
        cnt     <= 7'(PW);
      end else if (cnt != '0) begin
        rem  <= take ? (trial - {1'b0, den_mag}) : trial;
        quo  <= {quo[PW-2:0], take};
        cnt  <= cnt - 7'd1;
        done <= (cnt == 7'd1);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? -$signed(quo) : $signed(quo);
endmodule
`default_nettype wire

[hw/rtl/polygon_rect_clipper.sv]
// Sutherland-Hodgman clipper: vertices are taken back to back while loading; the clip
// runs after the final vertex, over four passes, with each crossing solved by the
// one-bit-per-cycle divider; results then leave one at a time, held while stalled.
// One polygon at a time; the next vertex is taken after the last result is accepted.
// Synchronous reset clears the count, overflow flag and control and loads the default
// window; vertex memories are not cleared.
`default_nettype none
module polygon_rect_clipper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [23:0] vertex_x,
  input  wire logic signed [23:0] vertex_y,
  input  wire logic        final_vertex,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic             out_last,
  output logic             out_empty,
  output logic             out_overflow
);
  localparam int CW = pcl_pkg::CNT_W;
  localparam int IW = pcl_pkg::IDX_W;
  localparam int DW = pcl_pkg::DIFF_W;
  localparam int PW = pcl_pkg::PROD_W;

  typedef enum logic [12:0] {
    S_LOAD  = 13'b0000000000001,
    S_PSTRT = 13'b0000000000010,
    S_PREV  = 13'b0000000000100,
    S_CUR   = 13'b0000000001000,
    S_MUL   = 13'b0000000010000,
    S_DGO   = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_CURW  = 13'b0000010000000,
    S_NEXT  = 13'b0000100000000,
    S_PEND  = 13'b0001000000000,
    S_OSTRT = 13'b0010000000000,
    S_ORD   = 13'b0100000000000,
    S_OWAIT = 13'b1000000000000
  } state_t;

  state_t state;
  logic signed [23:0] win_l, win_b, win_r, win_t;
  logic [CW-1:0] cnt, n, m, i;
  logic          ovf, sel, emit_cur, out_load;
  logic [1:0]    side;
  pcl_pkg::vtx_t prev, cur, rd, rd_a, rd_b, wdata;
  pcl_pkg::vtx_t mem_a [pcl_pkg::MAX_VERTS];
  pcl_pkg::vtx_t mem_b [pcl_pkg::MAX_VERTS];
  logic [IW-1:0] raddr, waddr;
  logic          we_a, we_b, wr;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] den;
  logic signed [23:0]   base, edge_v, pa, pb, ca, cb, xres;
  logic          pin, cin;
  pcl_pkg::div_req_t dreq;
  pcl_pkg::div_rsp_t drsp;

  function automatic logic inside_of(logic [1:0] s, pcl_pkg::vtx_t v,
                                     logic signed [23:0] l, logic signed [23:0] r,
                                     logic signed [23:0] b, logic signed [23:0] t);
    logic res;
    case (s)
      pcl_pkg::SIDE_LEFT:   res = v.x >= l;
      pcl_pkg::SIDE_RIGHT:  res = v.x <= r;
      pcl_pkg::SIDE_BOTTOM: res = v.y >= b;
      default:              res = v.y <= t;
    endcase
    return res;
  endfunction

  // boundary and axis selection for the current side
  always_comb begin
    case (side)
      pcl_pkg::SIDE_LEFT:   edge_v = win_l;
      pcl_pkg::SIDE_RIGHT:  edge_v = win_r;
      pcl_pkg::SIDE_BOTTOM: edge_v = win_b;
      default:              edge_v = win_t;
    endcase
    pa = side[1] ? prev.y : prev.x;
    pb = side[1] ? prev.x : prev.y;
    ca = side[1] ? cur.y : cur.x;
    cb = side[1] ? cur.x : cur.y;
  end

  assign rd  = sel ? rd_b : rd_a;
  assign pin = inside_of(side, prev, win_l, win_r, win_b, win_t);
  assign cin = inside_of(side, rd, win_l, win_r, win_b, win_t);
  assign xres = 24'(base + drsp.quo[23:0]);

  assign dreq.start = (state == S_DGO);
  assign dreq.num   = prod;
  assign dreq.den   = den;

  pcl_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // memory write and read address steering
  always_comb begin
    wr    = 1'b0;
    wdata = cur;
    waddr = m[IW-1:0];
    raddr = i[IW-1:0];
    case (state)
      S_LOAD: begin
        wr    = in_valid && (cnt < CW'(pcl_pkg::MAX_VERTS));
        wdata = '{x: vertex_x, y: vertex_y};
        waddr = cnt[IW-1:0];
      end
      S_PSTRT: raddr = IW'(n - CW'(1));
      S_PREV:  raddr = '0;
      S_CUR: begin
        wr    = pin && cin && (m < CW'(pcl_pkg::MAX_VERTS));
        wdata = rd;
      end
      S_DIV: begin
        wr    = drsp.done && (m < CW'(pcl_pkg::MAX_VERTS));
        wdata = side[1] ? '{x: xres, y: edge_v} : '{x: edge_v, y: xres};
      end
      S_CURW:  wr = m < CW'(pcl_pkg::MAX_VERTS);
      S_NEXT:  raddr = IW'(i + CW'(1));
      S_OSTRT: raddr = '0;
      S_OWAIT: raddr = IW'(i + CW'(1));
      default: ;
    endcase
    // loads go to store a; a pass writes the store it does not read
    we_a = wr && ((state == S_LOAD) || sel);
    we_b = wr && (state != S_LOAD) && !sel;
  end

  // store a and store b, registered read
  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    if (we_b) mem_b[waddr] <= wdata;
    rd_a <= mem_a[raddr];
    rd_b <= mem_b[raddr];
  end

  assign in_ready = (state == S_LOAD);
  assign out_overflow = ovf;
  assign out_load = (state == S_ORD);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_l <= pcl_pkg::RST_LEFT;
      win_b <= pcl_pkg::RST_BOTTOM;
      win_r <= pcl_pkg::RST_RIGHT;
      win_t <= pcl_pkg::RST_TOP;
    end else if (cfg_we) begin
      case (cfg_index)
        pcl_pkg::CFG_LEFT:   win_l <= cfg_data;
        pcl_pkg::CFG_BOTTOM: win_b <= cfg_data;
        pcl_pkg::CFG_RIGHT:  win_r <= cfg_data;
        default:             win_t <= cfg_data;
      endcase
    end
  end

  // crossing datapath: multiply, then hand to the divider
  always_ff @(posedge clk) begin
    if (state == S_CUR) cur <= rd;
    if (state == S_PREV) prev <= rd;
    if (state == S_NEXT) prev <= cur;
    if (state == S_MUL) begin
      prod <= PW'(($signed({edge_v[23], edge_v}) - $signed({pa[23], pa}))
                  * ($signed({cb[23], cb}) - $signed({pb[23], pb})));
      den  <= $signed({ca[23], ca}) - $signed({pa[23], pa});
      base <= pb;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      sel       <= 1'b0;
      side      <= pcl_pkg::SIDE_LEFT;
      n         <= '0;
      m         <= '0;
      i         <= '0;
      emit_cur  <= 1'b0;
    end else begin
      case (state)
        S_LOAD: if (in_valid) begin
          if (cnt < CW'(pcl_pkg::MAX_VERTS)) cnt <= cnt + CW'(1);
          else ovf <= 1'b1;
          if (final_vertex) begin
            n     <= (cnt < CW'(pcl_pkg::MAX_VERTS)) ? cnt + CW'(1) : cnt;
            side  <= pcl_pkg::SIDE_LEFT;
            sel   <= 1'b0;
            state <= S_PSTRT;
          end
        end
        S_PSTRT: begin
          m     <= '0;
          i     <= '0;
          state <= (n == '0) ? S_PEND : S_PREV;
        end
        S_PREV: state <= S_CUR;
        S_CUR: begin
          emit_cur <= cin;
          if (pin && cin) begin
            if (m < CW'(pcl_pkg::MAX_VERTS)) m <= m + CW'(1);
            state <= S_NEXT;
          end else if (pin || cin) state <= S_MUL;
          else state <= S_NEXT;
        end
        S_MUL: state <= S_DGO;
        S_DGO: state <= S_DIV;
        S_DIV: if (drsp.done) begin
          if (m < CW'(pcl_pkg::MAX_VERTS)) m <= m + CW'(1);
          state <= emit_cur ? S_CURW : S_NEXT;
        end
        S_CURW: begin
          if (m < CW'(pcl_pkg::MAX_VERTS)) m <= m + CW'(1);
          state <= S_NEXT;
        end
        S_NEXT: begin
          i     <= i + CW'(1);
          state <= (i + CW'(1) == n) ? S_PEND : S_CUR;
        end
        S_PEND: begin
          n    <= m;
          sel  <= ~sel;
          side <= side + 2'd1;
          state <= (side == pcl_pkg::SIDE_TOP) ? S_OSTRT : S_PSTRT;
        end
        S_OSTRT: begin
          i <= '0;
          if (n == '0) begin
            out_x     <= '0;
            out_y     <= '0;
            out_last  <= 1'b1;
            out_empty <= 1'b1;
            out_valid <= 1'b1;
            state     <= S_OWAIT;
          end else state <= S_ORD;
        end
        S_ORD: if (out_load) begin
          out_x     <= rd.x;
          out_y     <= rd.y;
          out_last  <= (i + CW'(1) == n);
          out_empty <= 1'b0;
          out_valid <= 1'b1;
          state     <= S_OWAIT;
        end
        S_OWAIT: if (out_ready) begin
          out_valid <= 1'b0;
          if (out_last) begin
            cnt   <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end else begin
            i     <= i + CW'(1);
            state <= S_ORD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/pcl_checker.sv]
// Port-level checks for polygon_rect_clipper, attached by bind.
// Depends only on the top-level ports.
`default_nettype none
module pcl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] out_x,
  input wire logic [23:0] out_y,
  input wire logic        out_last,
  input wire logic        out_empty
);
  // hold a stalled result request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("result changed while stalled");

  // never take vertices while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input open during output");

  // empty marker is the sole, zeroed item
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last && out_x == 24'd0 && out_y == 24'd0)
    else $error("malformed empty result");

  // reset drops any result
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind polygon_rect_clipper pcl_checker u_pcl_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
  .out_last(out_last), .out_empty(out_empty)
);
`default_nettype wire

[dv/polygon_rect_clipper_check.sv]
// Checker for the polygon rectangle clipper: watches both channels, predicts the
// clipped polygon for each closed vertex list and compares. Depends on pcl_pkg.
module polygon_rect_clipper_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic signed [23:0] vertex_x,
  input  logic signed [23:0] vertex_y,
  input  logic        final_vertex,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic signed [23:0] out_x,
  input  logic signed [23:0] out_y,
  input  logic        out_last,
  input  logic        out_empty,
  input  logic        out_overflow,
  output int          error_count,
  output int          pending_count
);

  typedef struct {
    longint x;
    longint y;
  } point_t;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic        last;
    logic        empty;
    logic        ovf;
  } clip_out_t;

  longint win_left, win_bottom, win_right, win_top;
  point_t loaded_verts[$];
  bit     dropped_vertex;
  clip_out_t clip_queue[$];

  assign pending_count = clip_queue.size();

  function automatic bit point_inside(int side, point_t p);
    case (side)
      pcl_pkg::SIDE_LEFT:   return p.x >= win_left;
      pcl_pkg::SIDE_RIGHT:  return p.x <= win_right;
      pcl_pkg::SIDE_BOTTOM: return p.y >= win_bottom;
      default:              return p.y <= win_top;
    endcase
  endfunction

  function automatic point_t edge_cross(int side, point_t a, point_t b);
    point_t r;
    longint e, d, n;
    if (side == pcl_pkg::SIDE_LEFT || side == pcl_pkg::SIDE_RIGHT) begin
      e = (side == pcl_pkg::SIDE_LEFT) ? win_left : win_right;
      d = b.x - a.x;
      n = (e - a.x) * (b.y - a.y);
      r.x = e;
      r.y = a.y + ((d != 0) ? n / d : 0);
    end else begin
      e = (side == pcl_pkg::SIDE_BOTTOM) ? win_bottom : win_top;
      d = b.y - a.y;
      n = (e - a.y) * (b.x - a.x);
      r.y = e;
      r.x = a.x + ((d != 0) ? n / d : 0);
    end
    return r;
  endfunction

  // Run the four clip passes over the loaded polygon and queue the results
  task automatic clip_polygon();
    point_t src[$];
    point_t dst[$];
    point_t cur, prv;
    bit ci, pi;
    clip_out_t o;
    int n;
    src = loaded_verts;
    for (int side = 0; side < 4; side++) begin
      dst = {};
      n = src.size();
      for (int i = 0; i < n; i++) begin
        cur = src[i];
        prv = src[(i + n - 1) % n];
        ci = point_inside(side, cur);
        pi = point_inside(side, prv);
        if (pi && ci) begin
          if (dst.size() < pcl_pkg::MAX_VERTS) dst = {dst, cur};
        end else if (pi) begin
          if (dst.size() < pcl_pkg::MAX_VERTS) dst = {dst, edge_cross(side, prv, cur)};
        end else if (ci) begin
          if (dst.size() < pcl_pkg::MAX_VERTS) dst = {dst, edge_cross(side, prv, cur)};
          if (dst.size() < pcl_pkg::MAX_VERTS) dst = {dst, cur};
        end
      end
      src = dst;
    end
    if (src.size() == 0) begin
      o = '{x: '0, y: '0, last: 1'b1, empty: 1'b1, ovf: dropped_vertex};
      clip_queue = {clip_queue, o};
    end else begin
      foreach (src[i]) begin
        o.x = src[i].x[23:0];
        o.y = src[i].y[23:0];
        o.last = (i == src.size() - 1);
        o.empty = 1'b0;
        o.ovf = dropped_vertex;
        clip_queue = {clip_queue, o};
      end
    end
    loaded_verts = {};
    dropped_vertex = 1'b0;
  endtask

  // Track config, predict on each request, compare each result
  always @(posedge clk) begin
    clip_out_t got, want;
    point_t p;
    if (rst) begin
      win_left <= 25600;
      win_bottom <= 25600;
      win_right <= 102400;
      win_top <= 102400;
      loaded_verts = {};
      dropped_vertex = 1'b0;
      clip_queue = {};
      error_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcl_pkg::CFG_LEFT:   win_left   <= longint'($signed(cfg_data));
          pcl_pkg::CFG_BOTTOM: win_bottom <= longint'($signed(cfg_data));
          pcl_pkg::CFG_RIGHT:  win_right  <= longint'($signed(cfg_data));
          default:             win_top    <= longint'($signed(cfg_data));
        endcase
      end
      if (in_valid && in_ready) begin
        p.x = longint'(vertex_x);
        p.y = longint'(vertex_y);
        if (loaded_verts.size() < pcl_pkg::MAX_VERTS) loaded_verts = {loaded_verts, p};
        else dropped_vertex = 1'b1;
        if (final_vertex) clip_polygon();
      end
      if (out_valid && out_ready) begin
        got = '{x: out_x, y: out_y, last: out_last, empty: out_empty, ovf: out_overflow};
        if (clip_queue.size() == 0) begin
          if (error_count < 10) $display("unexpected result %h", got);
          error_count <= error_count + 1;
        end else begin
          want = clip_queue.pop_front();
          if (got !== want) begin
            if (error_count < 10)
              $display("mismatch: exp x=%0d y=%0d l=%b e=%b o=%b, got x=%0d y=%0d l=%b e=%b o=%b",
                $signed(want.x), $signed(want.y), want.last, want.empty, want.ovf,
                $signed(got.x), $signed(got.y), got.last, got.empty, got.ovf);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule

[dv/polygon_rect_clipper_test.sv]
// Testbench top for the polygon rectangle clipper: drives polygons and window settings,
// sets the verdict. Depends on pcl_pkg, polygon_rect_clipper and polygon_rect_clipper_check.
module polygon_rect_clipper_test;

  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pcl_pkg::CFG_LEFT;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] vertex_x = '0;
  logic signed [23:0] vertex_y = '0;
  logic final_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] out_x, out_y;
  logic out_last, out_empty, out_overflow;
  int error_count, pending_count;
  int send_idle_pct = 20;
  int recv_idle_pct = 77;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polygon_rect_clipper dut (.*);
  polygon_rect_clipper_check checker_i (.*);

  // Drive receiver readiness
  always @(posedge clk) begin
    if (rst || recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one vertex; valid is left high after acceptance and dropped by the next idle
  task automatic send_vertex(logic signed [23:0] x, logic signed [23:0] y, bit fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    final_vertex <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_window(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord(int span);
    if ($urandom_range(9) == 0) return 24'($urandom());
    return 24'(int'($urandom_range(2 * span)) - span + 64000);
  endfunction

  // Send one polygon of the given size with random vertices
  task automatic send_polygon(int nverts, int span);
    for (int i = 0; i < nverts; i++)
      send_vertex(rand_coord(span), rand_coord(span), i == nverts - 1);
  endtask

  initial begin
    int items;
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a square straddling every side, one inside, one at the coordinate extremes, one single vertex
    send_vertex(24'sd0, 24'sd0, 0);
    send_vertex(24'sd128000, 24'sd0, 0);
    send_vertex(24'sd128000, 24'sd128000, 0);
    send_vertex(24'sd0, 24'sd128000, 1);
    send_vertex(24'sd30000, 24'sd30000, 0);
    send_vertex(24'sd90000, 24'sd30000, 0);
    send_vertex(24'sd60000, 24'sd90000, 1);
    send_vertex(-24'sd8388608, -24'sd8388608, 0);
    send_vertex(24'sd8388607, -24'sd8388608, 0);
    send_vertex(24'sd8388607, 24'sd8388607, 1);
    send_vertex(24'sd50000, 24'sd50000, 1);
    wait_drained();

    // Overflow: more than capacity, with the final vertex dropped
    for (int i = 0; i < pcl_pkg::MAX_VERTS + 3; i++)
      send_vertex(24'(40000 + 1000 * (i % 7)), 24'(30000 + 2000 * i),
                  i == pcl_pkg::MAX_VERTS + 2);
    wait_drained();

    // Window extremes, inverted window
    write_window(pcl_pkg::CFG_LEFT, 24'h800000);
    write_window(pcl_pkg::CFG_BOTTOM, 24'h800000);
    write_window(pcl_pkg::CFG_RIGHT, 24'h7fffff);
    write_window(pcl_pkg::CFG_TOP, 24'h7fffff);
    send_vertex(24'sd8388607, -24'sd8388608, 0);
    send_vertex(-24'sd8388608, 24'sd8388607, 0);
    send_vertex(24'sd0, 24'sd0, 1);
    wait_drained();
    write_window(pcl_pkg::CFG_LEFT, 24'd90000);
    write_window(pcl_pkg::CFG_RIGHT, 24'd40000);
    send_polygon(4, 60000);
    wait_drained();

    // Back-pressure: hold the receiver while polygons keep coming
    write_window(pcl_pkg::CFG_LEFT, 24'd25600);
    write_window(pcl_pkg::CFG_BOTTOM, 24'd25600);
    write_window(pcl_pkg::CFG_RIGHT, 24'd102400);
    write_window(pcl_pkg::CFG_TOP, 24'd102400);
    recv_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        send_polygon(6, 60000);
        send_polygon(6, 60000);
      end
    join
    wait_drained();

    // Random polygons in three idling phases
    items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 20 : 0;
      write_window(pcl_pkg::CFG_LEFT, 24'($urandom_range(40000) + 10000));
      write_window(pcl_pkg::CFG_BOTTOM, 24'($urandom_range(40000) + 10000));
      write_window(pcl_pkg::CFG_RIGHT, 24'($urandom_range(40000) + 70000));
      write_window(pcl_pkg::CFG_TOP, 24'($urandom_range(40000) + 70000));
      while (items < 80 * (phase + 1)) begin
        n = ($urandom_range(19) == 0) ? pcl_pkg::MAX_VERTS + 2 : int'($urandom_range(8, 1));
        send_polygon(n, ($urandom_range(1)) ? 60000 : 200000);
        items += n;
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
